@@ rtl/rcb_pkg.sv @@
`default_nettype none

package rcb_pkg;

  localparam int unsigned ColorW = 16;
  localparam int unsigned FpsW   = 8;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [ColorW-1:0] SeedReset = 16'h9B43;
  localparam logic [FpsW-1:0]   FpsReset  = 8'd6;

  // per-channel maxima, all carried at the green width
  localparam logic [5:0] RedMax   = 6'h1F;
  localparam logic [5:0] GreenMax = 6'h3F;
  localparam logic [5:0] BlueMax  = 6'h1F;

  // register index, taken from paddr bit 2 (word addressing)
  typedef enum logic {
    RegSeed = 1'b0,
    RegFps  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [5:0] level;
    logic       falling;
  } chan_t;

  // one bounce step: zero turns the channel upward, max turns it downward
  function automatic chan_t step_chan(input logic [5:0] level, input logic falling,
                                      input logic [5:0] max_level);
    chan_t res;
    res.falling = falling;
    if (level == 6'd0) res.falling = 1'b0;
    if (level == max_level) res.falling = 1'b1;
    res.level = res.falling ? (level - 6'd1) & max_level : (level + 6'd1) & max_level;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rcb_if.sv @@
`default_nettype none

interface rcb_in_if;
  logic valid;
  logic ready;
  logic vsync_n;

  modport source (output valid, output vsync_n, input ready);
  modport sink   (input valid, input vsync_n, output ready);
endinterface

interface rcb_out_if;
  import rcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

`default_nettype wire

@@ rtl/rgb565_color_bounce_on_vsync.sv @@
// Path: a sync sample accepted into the input register passes through one stage of
//   edge/bounce logic into the result register; a full, untaken result register can hold it back.
// Throughput: one sync sample per cycle; the input side stalls only when a color
//   item is due while the result register still holds an item nobody has taken.
// Reset (rst_ni, async, active low): levels load from the seed reset 0x9B43,
//   frames_per_step = 6, falling bits, blanking flag and edge count clear.
`default_nettype none

module rgb565_color_bounce_on_vsync (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  rcb_in_if.sink                          in_i,
  rcb_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rcb_pkg::AddrW-1:0]  paddr,
  input  wire logic [rcb_pkg::DataW-1:0]  pwdata,
  output logic      [rcb_pkg::DataW-1:0]  prdata,
  output logic                            pready
);
  import rcb_pkg::*;

  // ---------------- configuration registers ----------------
  logic [ColorW-1:0] seed_q;
  logic [FpsW-1:0]   fps_q;
  logic              cfg_wr;
  logic              wr_seed;
  logic              wr_fps;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign wr_seed = cfg_wr && (reg_idx == RegSeed);
  assign wr_fps  = cfg_wr && (reg_idx == RegFps);

  always_comb begin
    unique case (reg_idx)
      RegSeed: prdata = {{(DataW-ColorW){1'b0}}, seed_q};
      RegFps:  prdata = {{(DataW-FpsW){1'b0}}, fps_q};
      default: prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic in_valid_q;
  logic vsync_n_q;
  logic in_ready;
  logic in_fire;

  // ---------------- frame state ----------------
  logic [4:0]      red_q;
  logic [5:0]      green_q;
  logic [4:0]      blue_q;
  logic            red_fall_q, green_fall_q, blue_fall_q;
  logic            blank_q;
  logic [FpsW-1:0] cnt_q;

  // ---------------- result register ----------------
  logic              out_valid_q;
  logic [ColorW-1:0] color_q;

  // blanking start = first active-low sync sample outside blanking
  logic            sync_active;
  logic            vb_start;
  logic [FpsW-1:0] cnt_next;
  logic            hit;
  logic            go;
  logic            proc;
  logic            do_step;
  chan_t           red_n, green_n, blue_n;

  assign sync_active = !vsync_n_q;
  assign vb_start    = !blank_q && sync_active;
  assign cnt_next    = cnt_q + 8'd1;
  assign hit         = vb_start && (cnt_next == fps_q);

  // a sample that makes no color can always retire; one that does needs the slot
  assign go       = !hit || !out_valid_q || out_o.ready;
  assign proc     = in_valid_q && go;
  assign do_step  = proc && hit;
  assign in_ready = !in_valid_q || go;
  assign in_fire  = in_i.valid && in_ready;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.color = color_q;

  assign red_n   = step_chan({1'b0, red_q}, red_fall_q, RedMax);
  assign green_n = step_chan(green_q, green_fall_q, GreenMax);
  assign blue_n  = step_chan({1'b0, blue_q}, blue_fall_q, BlueMax);

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       <= SeedReset;
      fps_q        <= FpsReset;
      red_q        <= SeedReset[15:11];
      green_q      <= SeedReset[10:5];
      blue_q       <= SeedReset[4:0];
      red_fall_q   <= 1'b0;
      green_fall_q <= 1'b0;
      blue_fall_q  <= 1'b0;
      blank_q      <= 1'b0;
      cnt_q        <= '0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (wr_seed) begin
        seed_q <= pwdata[ColorW-1:0];
      end
      if (wr_fps) begin
        fps_q <= pwdata[FpsW-1:0];
      end

      // seed write reloads the levels; falling bits change only on a step
      if (wr_seed) begin
        red_q   <= pwdata[15:11];
        green_q <= pwdata[10:5];
        blue_q  <= pwdata[4:0];
      end else if (do_step) begin
        red_q   <= red_n.level[4:0];
        green_q <= green_n.level;
        blue_q  <= blue_n.level[4:0];
      end
      if (do_step) begin
        red_fall_q   <= red_n.falling;
        green_fall_q <= green_n.falling;
        blue_fall_q  <= blue_n.falling;
      end

      if (proc) begin
        if (vb_start) begin
          blank_q <= 1'b1;
          cnt_q   <= hit ? '0 : cnt_next;
        end else if (blank_q && !sync_active) begin
          blank_q <= 1'b0;
        end
      end

      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end

      if (do_step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vsync_n_q <= in_i.vsync_n;
    end
    if (do_step) begin
      color_q <= {red_n.level[4:0], green_n.level, blue_n.level[4:0]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/rcb_checker.sv @@
`default_nettype none

module rcb_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_vsync_n_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [rcb_pkg::ColorW-1:0] out_color_i
);
  import rcb_pkg::*;

  // a waiting color item stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("color item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_color_i))
    else $error("color changed while stalled");

  // input only backs up behind a full, stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a fresh result traces back to an accepted sample, via the input and result registers
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching sample");

  a_rise_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_vsync_n_i, 2))
    else $error("result from a sample outside sync");

endmodule

bind rgb565_color_bounce_on_vsync rcb_checker u_rcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_vsync_n_i (in_i.vsync_n),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_color_i  (out_o.color)
);

`default_nettype wire
